// File: rtl/core/bdil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_pkg: shared types and constants
// Item layouts, register codes and sizes for the 3x3 binary dilation core.
// ----------------------------------------------------------------------------
package bdil_pkg;

   // line store depth, 4 .. 4096
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // input row counter saturates at ROW_MAX
   localparam int ROW_W   = 12;
   localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

   // compare domain: holds MAX_WIDTH and a row count plus one
   localparam int CMP_W = ROW_W + 1;

   localparam int DIM_W = 11;
   localparam int SE_W  = 9;
   localparam int WIN   = 3;

   // structuring element edge masks, bit r*3+c
   localparam logic [SE_W-1:0] MASK_TOP   = 9'h007;
   localparam logic [SE_W-1:0] MASK_BOT   = 9'h1C0;
   localparam logic [SE_W-1:0] MASK_LEFT  = 9'h049;
   localparam logic [SE_W-1:0] MASK_RIGHT = 9'h124;
   localparam int CENTER = 4;

   // register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SE_MASK      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [SE_W-1:0]  SE_MASK_RESET      = 9'd511;
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // one window column, bit r = row r (row 0 top)
   typedef logic [WIN-1:0] column_type;

   typedef struct packed {
      logic pixel_in;
      logic drain;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic frame_end;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/bdil_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module bdil_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/bdil_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_cell: one column of the 3x3 window
// Holds three pixels and passes them to the left neighbor on each shift.
// ----------------------------------------------------------------------------
module bdil_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift,
   input  wire bdil_pkg::column_type  col_in,
   output bdil_pkg::column_type       col_q
);

   bdil_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_q = col_ff;

endmodule
`default_nettype wire

// File: rtl/core/bdil_rsp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_rsp_fifo: result queue
// Small register queue between the window stage and the result channel.
// ----------------------------------------------------------------------------
module bdil_rsp_fifo (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire bdil_pkg::rsp_type                  push_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bdil_pkg::rsp_type                       rsp_data,
   output logic [bdil_pkg::RSP_CNT_W-1:0]          count
);

   bdil_pkg::rsp_type                 slot_ff [bdil_pkg::RSP_DEPTH];
   logic [bdil_pkg::RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bdil_pkg::RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bdil_pkg::RSP_CNT_W-1:0]    count_ff, count_in;
   logic                              pop;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// File: rtl/core/binary_dilation_3x3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_dilation_3x3_core: streaming 3x3 binary dilation
// Raster pixel stream in, dilated stream out, one row plus one pixel behind.
// ----------------------------------------------------------------------------
//  channel   ports                          carries
//  request   req_valid/req_ready/req_data   pixel_in, drain
//  response  rsp_valid/rsp_ready/rsp_data   pixel_out, frame_end
//  csr       csr_valid/csr_ready/csr_index  se_mask, image_width, image_height
//            csr_data
//
// One item per cycle while req_ready is high; results pass the result queue.
// Line stores live in one RAM read at accept and written in the next cycle,
// with a bypass for back-to-back items on the same column.
// After reset a clearing pass zeros all MAX_WIDTH line store entries;
// req_ready stays low during it, csr writes are taken throughout.
// req_ready depends on registers only; it drops once the result queue plus
// the item in flight would fill it.
// ----------------------------------------------------------------------------
module binary_dilation_3x3_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire bdil_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bdil_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bdil_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bdil_pkg::CSR_DATA_W-1:0]     csr_data
);

   // configuration
   logic [bdil_pkg::SE_W-1:0]  se_mask_ff;
   logic [bdil_pkg::DIM_W-1:0] image_width_ff;
   logic [bdil_pkg::DIM_W-1:0] image_height_ff;

   // input and output position counters
   logic [bdil_pkg::COL_W-1:0] in_column_ff, in_column_in;
   logic [bdil_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [bdil_pkg::COL_W-1:0] out_column_ff, out_column_in;
   logic [bdil_pkg::ROW_W-1:0] out_row_ff, out_row_in;

   // line store clearing pass
   logic                       clr_active_ff;
   logic [bdil_pkg::COL_W-1:0] clr_addr_ff;

   // window stage
   logic                       s1_valid_ff;
   logic [bdil_pkg::COL_W-1:0] s1_col_ff;
   logic                       s1_px_ff;
   logic                       s1_emit_ff;
   logic [bdil_pkg::SE_W-1:0]  s1_mask_ff;
   logic                       s1_last_ff;
   logic                       fwd_hit_ff;
   logic [1:0]                 fwd_data_ff;

   logic                        accept;
   logic [bdil_pkg::CMP_W-1:0]  w_eff, h_eff;
   logic [bdil_pkg::CMP_W-1:0]  in_col_plus, out_col_plus, out_row_plus;
   logic                        in_wrap, out_wrap, last_row;
   logic                        px, emit, last;
   logic [bdil_pkg::SE_W-1:0]   mask;

   logic                       ram_wr_en;
   logic [bdil_pkg::COL_W-1:0] ram_wr_addr;
   logic [1:0]                 ram_wr_data;
   logic [1:0]                 ram_rd_data;
   logic [1:0]                 line_bits;
   logic [1:0]                 s1_wr_data;

   bdil_pkg::column_type       new_col;
   bdil_pkg::column_type       cell_q [bdil_pkg::WIN];
   bdil_pkg::column_type       cell_d [bdil_pkg::WIN];
   logic [bdil_pkg::SE_W-1:0]  window;
   bdil_pkg::rsp_type          push_data;
   logic                       push;
   logic [bdil_pkg::RSP_CNT_W-1:0] fifo_count;
   logic [bdil_pkg::RSP_CNT_W:0]   pending;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         se_mask_ff      <= bdil_pkg::SE_MASK_RESET;
         image_width_ff  <= bdil_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= bdil_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdil_pkg::CSR_SE_MASK:      se_mask_ff      <= csr_data[bdil_pkg::SE_W-1:0];
            bdil_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[bdil_pkg::DIM_W-1:0];
            bdil_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[bdil_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- accept
   assign pending   = {1'b0, fifo_count} + {{bdil_pkg::RSP_CNT_W{1'b0}},
                                            (s1_valid_ff && s1_emit_ff)};
   assign req_ready = !clr_active_ff && (pending < (bdil_pkg::RSP_CNT_W+1)'(bdil_pkg::RSP_DEPTH));
   assign accept    = req_valid && req_ready;

   always_comb begin
      // width clamps to 1..MAX_WIDTH, height zero counts as one
      if (image_width_ff == '0) begin
         w_eff = bdil_pkg::CMP_W'(1);
      end else if (bdil_pkg::CMP_W'(image_width_ff) > bdil_pkg::CMP_W'(bdil_pkg::MAX_WIDTH)) begin
         w_eff = bdil_pkg::CMP_W'(bdil_pkg::MAX_WIDTH);
      end else begin
         w_eff = bdil_pkg::CMP_W'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? bdil_pkg::CMP_W'(1) : bdil_pkg::CMP_W'(image_height_ff);

      px   = !req_data.drain && (bdil_pkg::CMP_W'(in_row_ff) < h_eff) && req_data.pixel_in;
      emit = (in_row_ff >= bdil_pkg::ROW_W'(2))
          || (in_row_ff == bdil_pkg::ROW_W'(1) && in_column_ff != '0);

      in_col_plus = bdil_pkg::CMP_W'(in_column_ff) + bdil_pkg::CMP_W'(1);
      in_wrap     = in_col_plus >= w_eff;

      out_col_plus = bdil_pkg::CMP_W'(out_column_ff) + bdil_pkg::CMP_W'(1);
      out_row_plus = bdil_pkg::CMP_W'(out_row_ff) + bdil_pkg::CMP_W'(1);
      out_wrap     = out_col_plus >= w_eff;
      last_row     = out_row_plus >= h_eff;
      last         = out_wrap && last_row;

      mask = se_mask_ff;
      if (out_row_ff == '0)    mask = mask & ~bdil_pkg::MASK_TOP;
      if (last_row)            mask = mask & ~bdil_pkg::MASK_BOT;
      if (out_column_ff == '0) mask = mask & ~bdil_pkg::MASK_LEFT;
      if (out_wrap)            mask = mask & ~bdil_pkg::MASK_RIGHT;

      in_column_in  = in_wrap ? '0 : in_col_plus[bdil_pkg::COL_W-1:0];
      in_row_in     = (in_wrap && in_row_ff != bdil_pkg::ROW_MAX) ? in_row_ff + 1'b1
                                                                  : in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (emit) begin
         if (last) begin
            // frame done: every counter restarts
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
         end else if (out_wrap) begin
            out_column_in = '0;
            out_row_in    = out_row_ff + 1'b1;
         end else begin
            out_column_in = out_col_plus[bdil_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else if (accept) begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   // ---------------------------------------------------------------- clear pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == bdil_pkg::COL_W'(bdil_pkg::MAX_WIDTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- line stores
   // bit 1 upper line, bit 0 middle line
   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_valid_ff;
         ram_wr_addr = s1_col_ff;
         ram_wr_data = s1_wr_data;
      end
   end

   bdil_ram #(
      .WIDTH (2),
      .DEPTH (bdil_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (in_column_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- window stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= in_column_ff;
         s1_px_ff   <= px;
         s1_emit_ff <= emit;
         s1_mask_ff <= mask;
         s1_last_ff <= last;
         // the write landing this cycle is missed by the read-first RAM
         fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == in_column_ff);
         fwd_data_ff <= s1_wr_data;
      end
   end

   assign line_bits  = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign s1_wr_data = {line_bits[0], s1_px_ff};
   assign new_col    = {s1_px_ff, line_bits[0], line_bits[1]};

   for (genvar c = 0; c < bdil_pkg::WIN; c++) begin : g_cell
      if (c == bdil_pkg::WIN - 1) begin : g_head
         assign cell_d[c] = new_col;
      end else begin : g_body
         assign cell_d[c] = cell_q[c+1];
      end
      bdil_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (s1_valid_ff),
         .col_in (cell_d[c]),
         .col_q  (cell_q[c])
      );
   end

   // window after this item's shift: the cells' inputs
   always_comb begin
      for (int r = 0; r < bdil_pkg::WIN; r++) begin
         for (int c = 0; c < bdil_pkg::WIN; c++) begin
            window[r*bdil_pkg::WIN + c] = cell_d[c][r];
         end
      end
   end

   assign push                = s1_valid_ff && s1_emit_ff;
   assign push_data.pixel_out = window[bdil_pkg::CENTER] || ((window & s1_mask_ff) != '0);
   assign push_data.frame_end = s1_last_ff;

   bdil_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

endmodule
`default_nettype wire

// File: rtl/core/bdil_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_checker: port-level checks for the dilation core
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module bdil_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire bdil_pkg::rsp_type  rsp_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response item changed while stalled");

   // nothing pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // line store clearing blocks input after reset
   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // an empty result queue refills only from an item accepted through the window stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response item without a request item");

endmodule

bind binary_dilation_3x3_core bdil_checker u_bdil_checker (.*);
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binary_dilation_3x3_core
// Drives raster frames through the dilation core and compares every result
// item against a bit-accurate dilation predictor. A short directed table of
// small frames comes first. Random phases follow, each with its own
// register setting, idle pattern and frame content.
// ----------------------------------------------------------------------------
module testbench;
   import bdil_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 240;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 140;
   localparam int MAX_GAP        = 40;
   localparam int HOLD_PHASE     = 4;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // window columns 1,2 move to 0,1 on each shift
   localparam logic [SE_W-1:0] KEEP_COLS = 9'h0DB;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      bit                is_cfg;
      logic [DIM_W-1:0]  mask_data;
      logic [DIM_W-1:0]  width_data;
      logic [DIM_W-1:0]  height_data;
      req_type           item;
      bit                known;
      rsp_type           result;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [SE_W-1:0]  cfg_mask;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   bit               top_store [MAX_WIDTH];
   bit               mid_store [MAX_WIDTH];
   logic [SE_W-1:0]  win_bits;
   int unsigned      in_col, in_row, out_col, out_row;

   rsp_type     dilated_q [$];
   dir_row_type dir_rows [$];

   int mismatches = 0;
   int stall_cycles = 0;
   int phase_items = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;

   binary_dilation_3x3_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   task automatic dilate_predict(input req_type d, output bit produced, output rsp_type r);
      int unsigned w, h, col;
      bit px, top, mid, emit;
      logic [SE_W-1:0] mask;
      w = eff_width();
      h = eff_height();
      col = (in_col < MAX_WIDTH) ? in_col : 0;
      // drains and pixels past the last row enter as zero
      px = (!d.drain && in_row < h) ? d.pixel_in : 1'b0;
      top = top_store[col];
      mid = mid_store[col];
      top_store[col] = mid;
      mid_store[col] = px;
      win_bits = ((win_bits >> 1) & KEEP_COLS) | {px, 2'b00, mid, 2'b00, top, 2'b00};
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         if (in_row < ROW_MAX) in_row++;
      end
      produced = emit;
      r = '0;
      if (emit) begin
         mask = cfg_mask;
         if (out_row == 0) mask &= ~MASK_TOP;
         if (out_row + 1 >= h) mask &= ~MASK_BOT;
         if (out_col == 0) mask &= ~MASK_LEFT;
         if (out_col + 1 >= w) mask &= ~MASK_RIGHT;
         r.pixel_out = win_bits[CENTER] | (|(win_bits & mask));
         r.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
         if (r.frame_end) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      end
   endtask

   task automatic send_item(input req_type d, input bit use_typed, input rsp_type typed,
                            output bit ended);
      int gap;
      bit produced;
      rsp_type r;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      dilate_predict(d, produced, r);
      if (use_typed) dilated_q.push_back(typed);
      else if (produced) dilated_q.push_back(r);
      ended = use_typed ? typed.frame_end : (produced && r.frame_end);
      phase_items++;
   endtask

   // lower valid, let every expected item arrive, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (dilated_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [DIM_W-1:0] mask_data, input logic [DIM_W-1:0] wdata,
                             input logic [DIM_W-1:0] hdata, input bit junk);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [DIM_W-1:0] val [4];
      int n;
      idx = '{CSR_SE_MASK, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_UNMAPPED};
      val = '{mask_data, wdata, hdata, DIM_W'($urandom)};
      n = junk ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            CSR_SE_MASK:      cfg_mask = val[i][SE_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_width = val[i];
            CSR_IMAGE_HEIGHT: cfg_height = val[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // frame that follows the predicted raster position, so it lines up even
   // after a register change left the previous one half done
   task automatic send_frame(input int density, input bit may_abort);
      req_type d;
      bit ended;
      ended = 1'b0;
      while (!ended) begin
         if (may_abort && phase_items >= PHASE_ITEMS) return;
         if (in_row < eff_height()) begin
            d.drain = ($urandom_range(99) < 4);
            d.pixel_in = ($urandom_range(99) < density);
         end else begin
            d.drain = ($urandom_range(99) >= 10);
            d.pixel_in = $urandom_range(1);
         end
         send_item(d, 1'b0, '0, ended);
      end
   endtask

   task automatic add_cfg(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h);
      dir_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.mask_data = m;
      row.width_data = w;
      row.height_data = h;
      dir_rows.push_back(row);
   endtask

   task automatic add_item(input bit px, input bit dr, input bit known, input bit out_px,
                           input bit out_end);
      dir_row_type row;
      row = '{default: '0};
      row.item.pixel_in = px;
      row.item.drain = dr;
      row.known = known;
      row.result.pixel_out = out_px;
      row.result.frame_end = out_end;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dilated_q.size() == 0) begin
            $error("unexpected result item: pixel_out %0b frame_end %0b",
                   rsp_data.pixel_out, rsp_data.frame_end);
            mismatches++;
         end else begin
            want = dilated_q.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out) begin
               $error("pixel_out: expected %0b, actual %0b", want.pixel_out, rsp_data.pixel_out);
               mismatches++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_data.frame_end);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      idle_mode_type mode;
      logic [DIM_W-1:0] m, w, h;
      bit ended, may_abort;

      cfg_mask = SE_MASK_RESET;
      cfg_width = IMAGE_WIDTH_RESET;
      cfg_height = IMAGE_HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         top_store[i] = 1'b0;
         mid_store[i] = 1'b0;
      end
      win_bits = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;

      // single-pixel frames give back the pixel itself
      add_cfg(11'd511, 11'd1, 11'd1);
      add_item(1, 0, 0, 0, 0);
      add_item(0, 1, 0, 0, 0);
      add_item(0, 1, 1, 1, 1);
      // drain inside the frame reads as zero whatever pixel_in holds
      add_item(1, 1, 0, 0, 0);
      add_item(1, 1, 0, 0, 0);
      add_item(0, 1, 1, 0, 1);
      // pixels past the last row are ignored
      add_item(1, 0, 0, 0, 0);
      add_item(1, 0, 0, 0, 0);
      add_item(1, 0, 1, 1, 1);
      // zero width and height count as one
      add_cfg(11'd0, 11'd0, 11'd0);
      add_item(1, 0, 0, 0, 0);
      add_item(0, 1, 0, 0, 0);
      add_item(0, 1, 1, 1, 1);
      add_item(0, 0, 0, 0, 0);
      add_item(1, 0, 0, 0, 0);
      add_item(1, 0, 1, 0, 1);
      // bits above the element are dropped
      add_cfg(11'h7FF, 11'd3, 11'd2);
      add_item(1, 0, 0, 0, 0);
      add_item(0, 0, 0, 0, 0);
      add_item(0, 0, 0, 0, 0);
      add_item(0, 0, 0, 0, 0);
      add_item(0, 0, 0, 0, 0);
      add_item(1, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) add_item(0, 1, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            wait_idle();
            write_regs(dir_rows[i].mask_data, dir_rows[i].width_data,
                       dir_rows[i].height_data, 1'b0);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].result, ended);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         m = {2'($urandom_range(3)), 9'($urandom_range(511))};
         case (phase)
            0: begin m = 11'd511; w = 11'd4; h = 11'd3; end
            1: begin m = 11'd0; w = 11'd5; h = 11'd4; end
            2: begin w = 11'd2047; h = 11'd1; end
            3: begin w = 11'd1; h = 11'd2047; end
            default: begin
               w = ($urandom_range(7) == 0) ? 11'd0
                   : 11'($urandom_range(1, $urandom_range(1) ? 8 : 40));
               h = ($urandom_range(7) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
            end
         endcase
         wait_idle();
         write_regs(m, w, h, phase == 6);

         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 66; rx_stall_pct <= 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct <= 66; end
            default:       begin tx_idle_pct = 30; rx_stall_pct <= 30; end
         endcase
         if (phase == HOLD_PHASE) hold_trigger <= hold_trigger + 1;

         // the two oversized frames always stop part way; small frames may
         // stop so the next setting lands mid-frame
         may_abort = (phase == 2) || (phase == 3)
                  || ((eff_width() * eff_height() <= 64) && ($urandom_range(3) == 0));
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_frame($urandom_range(100), may_abort);
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: binary_dilation_3x3_core.f
rtl/core/bdil_pkg.sv
rtl/core/bdil_ram.sv
rtl/core/bdil_cell.sv
rtl/core/bdil_rsp_fifo.sv
rtl/core/binary_dilation_3x3_core.sv
rtl/core/bdil_checker.sv
bench/testbench.sv
